[hw/rtl/disd_pkg.sv]
// ----------------------------------------------------------------------------
// disd_pkg
// Shared types and constants for the DER sequence-of-integer decoder.
// ----------------------------------------------------------------------------
package disd_pkg;

  // DER tag and length codes.
  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] LEN_LONG     = 8'h80;
  localparam logic [7:0] LEN_ONE_BYTE = 8'h81;
  localparam logic [7:0] LEN_TWO_BYTE = 8'h82;

  // Reset value of the integer length limit.
  localparam logic [15:0] MAX_INT_BYTES_RST = 16'd512;

  // Saturation limits of the running counters.
  localparam logic [16:0] CHILD_MAX = 17'h1FFFF;
  localparam logic [14:0] COUNT_MAX = 15'h7FFF;

  // Result queue geometry.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  // Kinds of result.
  typedef enum logic [1:0] {
    KIND_CONTENT  = 2'd0,
    KIND_OVERFLOW = 2'd1,
    KIND_STATUS   = 2'd2
  } result_kind_t;

  // Final status codes.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_MALFORMED = 1'b1;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_LEN0    = 3'd1,
    PH_LEN81   = 3'd2,
    PH_LENHI   = 3'd3,
    PH_LENLO   = 3'd4,
    PH_CONTENT = 3'd5
  } phase_t;

  // One result item.
  typedef struct packed {
    result_kind_t kind;
    logic [14:0]  integer_index;
    logic [7:0]   content_byte;
    logic [15:0]  byte_significance;
    logic         last_of_integer;
    logic         decode_status;
    logic [14:0]  integer_count;
  } result_t;

  // Push requests from the parser: slot a goes in before slot b.
  typedef struct packed {
    logic a;
    logic b;
  } push_t;

endpackage

[hw/rtl/disd_parser.sv]
// ----------------------------------------------------------------------------
// disd_parser
// Byte-wise DER header and content parser; produces up to two results per
// accepted byte (an element result and the final status).
// ----------------------------------------------------------------------------
module disd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic              last_byte,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output disd_pkg::push_t   push,
  output disd_pkg::result_t res_a,
  output disd_pkg::result_t res_b
);

  typedef struct packed {
    disd_pkg::phase_t phase;
    logic             outer_hdr;
    logic [7:0]       len_hi;
    logic [15:0]      remaining;
    logic             overflow;
    logic [15:0]      outer_len;
    logic [16:0]      children;
    logic [14:0]      int_count;
    logic             malformed;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:     disd_pkg::PH_TAG,
    outer_hdr: 1'b1,
    len_hi:    8'd0,
    remaining: 16'd0,
    overflow:  1'b0,
    outer_len: 16'd0,
    children:  17'd0,
    int_count: 15'd0,
    malformed: 1'b0
  };

  parse_state_t st_r, st_cur, st_nxt;
  logic [15:0]  max_bytes_r;
  logic         hdr_fire;
  logic [15:0]  hdr_len;
  logic         push_a_raw, push_b_raw;
  logic         bad;

  // Next parse state and results for the byte on the input.
  always_comb begin
    st_cur     = first_byte ? PARSE_CLEAR : st_r;
    st_nxt     = st_cur;
    hdr_fire   = 1'b0;
    hdr_len    = 16'd0;
    push_a_raw = 1'b0;
    push_b_raw = 1'b0;
    res_a      = '0;
    res_b      = '0;
    bad        = 1'b0;

    if (!st_cur.malformed) begin
      if (!st_cur.outer_hdr && st_cur.children != disd_pkg::CHILD_MAX) begin
        st_nxt.children = st_cur.children + 17'd1;
      end
      unique case (st_cur.phase)
        disd_pkg::PH_TAG: begin
          if (data_byte == disd_pkg::TAG_INTEGER ||
              (st_cur.outer_hdr && data_byte == disd_pkg::TAG_SEQUENCE)) begin
            st_nxt.phase = disd_pkg::PH_LEN0;
          end else begin
            st_nxt.malformed = 1'b1;
          end
        end
        disd_pkg::PH_LEN0: begin
          if (data_byte != 8'd0 && data_byte < disd_pkg::LEN_LONG) begin
            hdr_fire = 1'b1;
            hdr_len  = {8'd0, data_byte};
          end else if (data_byte == disd_pkg::LEN_ONE_BYTE) begin
            st_nxt.phase = disd_pkg::PH_LEN81;
          end else if (data_byte == disd_pkg::LEN_TWO_BYTE) begin
            st_nxt.phase = disd_pkg::PH_LENHI;
          end else begin
            st_nxt.malformed = 1'b1;
          end
        end
        disd_pkg::PH_LEN81: begin
          if (data_byte >= disd_pkg::LEN_LONG) begin
            hdr_fire = 1'b1;
            hdr_len  = {8'd0, data_byte};
          end else begin
            st_nxt.malformed = 1'b1;
          end
        end
        disd_pkg::PH_LENHI: begin
          if (data_byte != 8'd0) begin
            st_nxt.len_hi = data_byte;
            st_nxt.phase  = disd_pkg::PH_LENLO;
          end else begin
            st_nxt.malformed = 1'b1;
          end
        end
        disd_pkg::PH_LENLO: begin
          hdr_fire = 1'b1;
          hdr_len  = {st_cur.len_hi, data_byte};
        end
        disd_pkg::PH_CONTENT: begin
          if (st_cur.remaining == 16'd0) begin
            st_nxt.malformed = 1'b1;
          end else begin
            if (!st_cur.overflow) begin
              push_a_raw              = 1'b1;
              res_a.kind              = disd_pkg::KIND_CONTENT;
              res_a.integer_index     = st_cur.int_count;
              res_a.content_byte      = data_byte;
              res_a.byte_significance = st_cur.remaining - 16'd1;
              res_a.last_of_integer   = (st_cur.remaining == 16'd1);
            end
            st_nxt.remaining = st_cur.remaining - 16'd1;
            if (st_cur.remaining == 16'd1) begin
              if (st_cur.int_count != disd_pkg::COUNT_MAX) begin
                st_nxt.int_count = st_cur.int_count + 15'd1;
              end
              st_nxt.overflow = 1'b0;
              st_nxt.phase    = disd_pkg::PH_TAG;
            end
          end
        end
        default: begin
          st_nxt.malformed = 1'b1;
        end
      endcase

      // A completed length closes either the outer header or an element header.
      if (hdr_fire) begin
        if (st_cur.outer_hdr) begin
          st_nxt.outer_len = hdr_len;
          st_nxt.outer_hdr = 1'b0;
          st_nxt.phase     = disd_pkg::PH_TAG;
        end else begin
          st_nxt.remaining = hdr_len;
          st_nxt.overflow  = (hdr_len > max_bytes_r);
          st_nxt.phase     = disd_pkg::PH_CONTENT;
          if (hdr_len > max_bytes_r) begin
            push_a_raw            = 1'b1;
            res_a.kind            = disd_pkg::KIND_OVERFLOW;
            res_a.integer_index   = st_cur.int_count;
            res_a.last_of_integer = 1'b1;
          end
        end
      end
    end

    // The last byte reports the status and returns the parser to its start.
    if (last_byte) begin
      bad = st_nxt.malformed || st_nxt.outer_hdr ||
            (st_nxt.phase != disd_pkg::PH_TAG) ||
            (st_nxt.children != {1'b0, st_nxt.outer_len});
      push_b_raw          = 1'b1;
      res_b.kind          = disd_pkg::KIND_STATUS;
      res_b.decode_status = bad ? disd_pkg::STATUS_MALFORMED : disd_pkg::STATUS_OK;
      res_b.integer_count = st_nxt.int_count;
      st_nxt              = PARSE_CLEAR;
    end
  end

  assign push.a = acc && push_a_raw;
  assign push.b = acc && push_b_raw;

  // Parse state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PARSE_CLEAR;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

  // Integer length limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= disd_pkg::MAX_INT_BYTES_RST;
    end else if (cfg_wr_en) begin
      max_bytes_r <= cfg_wr_data;
    end
  end

  // After a status result the parser is back at the outer tag.
  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push.b |=> (st_r.phase == disd_pkg::PH_TAG) && st_r.outer_hdr &&
               (st_r.int_count == 15'd0) && (st_r.children == 17'd0))
    else $error("parser state not cleared after status");

  // Content bytes come only from the content phase of a non-overflowing integer.
  a_content_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (push.a && res_a.kind == disd_pkg::KIND_CONTENT) |->
      (st_cur.phase == disd_pkg::PH_CONTENT) && !st_cur.overflow)
    else $error("content byte outside content phase");

  // Overflow markers come only at the end of an element length.
  a_marker_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (push.a && res_a.kind == disd_pkg::KIND_OVERFLOW) |->
      !st_cur.outer_hdr && (st_cur.phase == disd_pkg::PH_LEN0 ||
      st_cur.phase == disd_pkg::PH_LEN81 || st_cur.phase == disd_pkg::PH_LENLO))
    else $error("overflow marker outside element header");

endmodule

[hw/rtl/disd_out_fifo.sv]
// ----------------------------------------------------------------------------
// disd_out_fifo
// Small queue: takes up to two results per cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
module disd_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  disd_pkg::push_t   push,
  input  disd_pkg::result_t res_a,
  input  disd_pkg::result_t res_b,
  output logic              almost_full,
  output logic              out_valid,
  input  logic              out_stall,
  output disd_pkg::result_t out_res
);

  localparam int PW = disd_pkg::OUT_PTR_W;

  disd_pkg::result_t    mem_r [disd_pkg::OUT_DEPTH];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]          count_r, count_nxt;
  logic [1:0]           n_push;
  logic                 pop;
  disd_pkg::result_t    wr_first;

  assign n_push   = {1'b0, push.a} + {1'b0, push.b};
  assign pop      = out_valid && !out_stall;
  assign wr_first = push.a ? res_a : res_b;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(n_push);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + (PW+1)'(n_push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage: slot a first, slot b behind it when both are pushed.
  always_ff @(posedge clk) begin
    if (push.a || push.b) begin
      mem_r[wr_ptr_r] <= wr_first;
    end
    if (push.a && push.b) begin
      mem_r[wr_ptr_r + PW'(1)] <= res_b;
    end
  end

  assign out_valid   = (count_r != '0);
  assign out_res     = mem_r[rd_ptr_r];
  assign almost_full = (count_r > (PW+1)'(disd_pkg::OUT_DEPTH - 2));

  // The fill level never passes the depth.
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(disd_pkg::OUT_DEPTH))
    else $error("result queue overfilled");

  // Pushes arrive only while room for two results is left.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0) |-> !almost_full)
    else $error("push into result queue without room");

  // A pop with no push lowers the fill level by one.
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && n_push == 2'd0) |=> (count_r == $past(count_r) - (PW+1)'(1)))
    else $error("result queue fill level wrong after pop");

endmodule

[hw/rtl/der_integer_sequence_decoder_top.sv]
// ----------------------------------------------------------------------------
// der_integer_sequence_decoder_top
// Throughput: one byte per cycle; a byte yields at most two results, which a
// four-entry result queue absorbs; input stalls while fewer than two entries are free.
// Reset: synchronous, active low; clears the parser, the result queue and sets
// the integer length limit to 512 bytes.
// ----------------------------------------------------------------------------
module der_integer_sequence_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // Results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [14:0] out_integer_index,
  output logic [7:0]  out_content_byte,
  output logic [15:0] out_byte_significance,
  output logic        out_last_of_integer,
  output logic        out_decode_status,
  output logic [14:0] out_integer_count
);

  logic              acc;
  logic              almost_full;
  disd_pkg::push_t   push;
  disd_pkg::result_t res_a, res_b, out_res;

  // Input transaction accepted when the queue has room for two results.
  assign in_stall = almost_full;
  assign acc      = in_valid && !in_stall;

  disd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .data_byte   (in_data_byte),
    .first_byte  (in_first_byte),
    .last_byte   (in_last_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .res_a       (res_a),
    .res_b       (res_b)
  );

  disd_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .res_a       (res_a),
    .res_b       (res_b),
    .almost_full (almost_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res)
  );

  // Result fields onto their own ports.
  assign out_result_kind       = out_res.kind;
  assign out_integer_index     = out_res.integer_index;
  assign out_content_byte      = out_res.content_byte;
  assign out_byte_significance = out_res.byte_significance;
  assign out_last_of_integer   = out_res.last_of_integer;
  assign out_decode_status     = out_res.decode_status;
  assign out_integer_count     = out_res.integer_count;

endmodule

[tb/tb_der_integer_sequence_decoder_top.sv]
// ----------------------------------------------------------------------------
// tb_der_integer_sequence_decoder_top
// Self-checking bench for the DER sequence-of-integer decoder. Byte
// transactions are driven with random gaps and the result channel is stalled
// at random. A cycle-free predictor of the parser computes the expected
// results of every accepted byte, and each result is checked field by field.
// The bench covers directed cases, a long message with two-byte lengths sent
// without idling, and random messages that are well formed, damaged or pure
// noise.
// ----------------------------------------------------------------------------
module tb_der_integer_sequence_decoder_top;

  timeunit 1ns;
  timeprecision 1ps;

  // Ways of damaging a well-formed message.
  typedef enum int {
    DMG_BYTE,
    DMG_TRUNCATE,
    DMG_APPEND,
    DMG_NOISE
  } damage_t;

  // Clock, reset and block ports.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [14:0] out_integer_index;
  logic [7:0]  out_content_byte;
  logic [15:0] out_byte_significance;
  logic        out_last_of_integer;
  logic        out_decode_status;
  logic [14:0] out_integer_count;

  // Predictor state: a copy of the parser and of the length limit.
  disd_pkg::phase_t hdr_phase;
  logic        at_outer;
  logic [7:0]  len_msb;
  logic [15:0] int_left;
  logic        int_too_long;
  logic [15:0] seq_len;
  logic [16:0] seq_seen;
  logic [14:0] int_total;
  logic        msg_bad;
  logic [15:0] int_limit;

  // Results still owed by the block, oldest first.
  disd_pkg::result_t pending_results[$];
  // Message under construction.
  logic [7:0]  msg[$];

  int          fails = 0;
  int          sent_items = 0;
  bit          calm = 1'b0;

  der_integer_sequence_decoder_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_first_byte         (in_first_byte),
    .in_last_byte          (in_last_byte),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_kind       (out_result_kind),
    .out_integer_index     (out_integer_index),
    .out_content_byte      (out_content_byte),
    .out_byte_significance (out_byte_significance),
    .out_last_of_integer   (out_last_of_integer),
    .out_decode_status     (out_decode_status),
    .out_integer_count     (out_integer_count)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Returns the parser to the state of an outer tag expected.
  function automatic void reset_parser();
    hdr_phase    = disd_pkg::PH_TAG;
    at_outer     = 1'b1;
    len_msb      = 8'h00;
    int_left     = 16'h0000;
    int_too_long = 1'b0;
    seq_len      = 16'h0000;
    seq_seen     = 17'h00000;
    int_total    = 15'h0000;
    msg_bad      = 1'b0;
  endfunction

  function automatic void queue_result(disd_pkg::result_kind_t kind, logic [14:0] idx,
                                       logic [7:0] data, logic [15:0] sig,
                                       logic lsb, logic status,
                                       logic [14:0] count);
    disd_pkg::result_t r;
    r.kind              = kind;
    r.integer_index     = idx;
    r.content_byte      = data;
    r.byte_significance = sig;
    r.last_of_integer   = lsb;
    r.decode_status     = status;
    r.integer_count     = count;
    pending_results.push_back(r);
  endfunction

  // A complete length: either the outer length, or an integer begins.
  function automatic void close_header(logic [15:0] len);
    if (at_outer) begin
      seq_len   = len;
      at_outer  = 1'b0;
      hdr_phase = disd_pkg::PH_TAG;
    end else begin
      int_left     = len;
      int_too_long = (len > int_limit);
      hdr_phase    = disd_pkg::PH_CONTENT;
      if (int_too_long) begin
        queue_result(disd_pkg::KIND_OVERFLOW, int_total, 8'h00, 16'h0000, 1'b1,
                     disd_pkg::STATUS_OK, 15'h0000);
      end
    end
  endfunction

  // Works out the results of one accepted byte and advances the parser.
  function automatic void decode_byte(logic [7:0] b, logic first, logic last);
    logic status;
    if (first) begin
      reset_parser();
    end
    if (!msg_bad) begin
      if (!at_outer && seq_seen != disd_pkg::CHILD_MAX) begin
        seq_seen = seq_seen + 17'd1;
      end
      case (hdr_phase)
        disd_pkg::PH_TAG: begin
          if (b == disd_pkg::TAG_INTEGER || (at_outer && b == disd_pkg::TAG_SEQUENCE)) begin
            hdr_phase = disd_pkg::PH_LEN0;
          end else begin
            msg_bad = 1'b1;
          end
        end
        disd_pkg::PH_LEN0: begin
          if (b != 8'h00 && b < disd_pkg::LEN_LONG) begin
            close_header({8'h00, b});
          end else if (b == disd_pkg::LEN_ONE_BYTE) begin
            hdr_phase = disd_pkg::PH_LEN81;
          end else if (b == disd_pkg::LEN_TWO_BYTE) begin
            hdr_phase = disd_pkg::PH_LENHI;
          end else begin
            msg_bad = 1'b1;
          end
        end
        disd_pkg::PH_LEN81: begin
          if (b >= disd_pkg::LEN_LONG) begin
            close_header({8'h00, b});
          end else begin
            msg_bad = 1'b1;
          end
        end
        disd_pkg::PH_LENHI: begin
          if (b != 8'h00) begin
            len_msb   = b;
            hdr_phase = disd_pkg::PH_LENLO;
          end else begin
            msg_bad = 1'b1;
          end
        end
        disd_pkg::PH_LENLO: begin
          close_header({len_msb, b});
        end
        disd_pkg::PH_CONTENT: begin
          if (int_left == 16'h0000) begin
            msg_bad = 1'b1;
          end else begin
            if (!int_too_long) begin
              queue_result(disd_pkg::KIND_CONTENT, int_total, b, int_left - 16'd1,
                           int_left == 16'd1, disd_pkg::STATUS_OK, 15'h0000);
            end
            int_left = int_left - 16'd1;
            if (int_left == 16'h0000) begin
              if (int_total != disd_pkg::COUNT_MAX) begin
                int_total = int_total + 15'd1;
              end
              int_too_long = 1'b0;
              hdr_phase    = disd_pkg::PH_TAG;
            end
          end
        end
        default: begin
          msg_bad = 1'b1;
        end
      endcase
    end
    if (last) begin
      status = (msg_bad || at_outer || hdr_phase != disd_pkg::PH_TAG ||
                seq_seen != {1'b0, seq_len})
               ? disd_pkg::STATUS_MALFORMED : disd_pkg::STATUS_OK;
      queue_result(disd_pkg::KIND_STATUS, 15'h0000, 8'h00, 16'h0000, 1'b0, status,
                   int_total);
      reset_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Each accepted result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    disd_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: kind %0d, index %0d", out_result_kind,
               out_integer_index);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.kind, out_result_kind);
        check_field("integer_index", want.integer_index, out_integer_index);
        check_field("content_byte", want.content_byte, out_content_byte);
        check_field("byte_significance", want.byte_significance, out_byte_significance);
        check_field("last_of_integer", want.last_of_integer, out_last_of_integer);
        check_field("decode_status", want.decode_status, out_decode_status);
        check_field("integer_count", want.integer_count, out_integer_count);
      end
    end
  end

  // Random back-pressure on the result channel, none during a calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 29);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one byte transaction, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_first_byte <= first;
    in_last_byte  <= last;
    do @(posedge clk); while (in_stall);
    decode_byte(b, first, last);
    sent_items++;
  endtask

  task automatic send_message(input logic first_head, input logic last_tail);
    foreach (msg[i]) begin
      send_byte(msg[i], first_head && i == 0, last_tail && i == msg.size() - 1);
    end
  endtask

  // Waits until every expected result has arrived and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    int_limit = value;
  endtask

  // Appends a length in the shortest form the decoder accepts.
  function automatic void push_length(int len);
    if (len < 128) begin
      msg.push_back(8'(len));
    end else if (len < 256) begin
      msg.push_back(disd_pkg::LEN_ONE_BYTE);
      msg.push_back(8'(len));
    end else begin
      msg.push_back(disd_pkg::LEN_TWO_BYTE);
      msg.push_back(8'(len >> 8));
      msg.push_back(8'(len));
    end
  endfunction

  // Builds a random message: mostly well formed, sometimes damaged or noise.
  function automatic void build_random_message();
    logic [7:0] body[$];
    int         len;
    int         cut;
    damage_t    damage;
    msg.delete();
    repeat ($urandom_range(1, 4)) begin
      len = ($urandom_range(49) == 0) ? $urandom_range(120, 300) : $urandom_range(1, 4);
      msg.push_back(disd_pkg::TAG_INTEGER);
      push_length(len);
      repeat (len) msg.push_back(8'($urandom));
    end
    body = msg;
    msg.delete();
    msg.push_back($urandom_range(1) ? disd_pkg::TAG_SEQUENCE : disd_pkg::TAG_INTEGER);
    push_length(body.size());
    foreach (body[i]) msg.push_back(body[i]);
    if ($urandom_range(99) < 30) begin
      damage = damage_t'($urandom_range(3));
      case (damage)
        DMG_BYTE: begin
          msg[$urandom_range(msg.size() - 1)] = 8'($urandom);
        end
        DMG_TRUNCATE: begin
          cut = $urandom_range(1, 3);
          while (cut > 0 && msg.size() > 1) begin
            void'(msg.pop_back());
            cut--;
          end
        end
        DMG_APPEND: begin
          repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
        end
        default: begin
          msg.delete();
          repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Two good messages, one of each outer tag; the second starts without
  // first_byte, relying on the parser restart after the previous last byte.
  task automatic test_well_formed();
    msg = '{disd_pkg::TAG_SEQUENCE, 8'h06, disd_pkg::TAG_INTEGER, 8'h01, 8'h00,
            disd_pkg::TAG_INTEGER, 8'h01, 8'hFF};
    send_message(1'b1, 1'b1);
    msg = '{disd_pkg::TAG_INTEGER, 8'h03, disd_pkg::TAG_INTEGER, 8'h01, 8'h80};
    send_message(1'b0, 1'b1);
  endtask

  // With a zero limit every integer overflows; ending on the length byte gives
  // the overflow marker and the status in one transaction.
  task automatic test_zero_limit();
    write_limit(16'h0000);
    msg = '{disd_pkg::TAG_SEQUENCE, 8'h03, disd_pkg::TAG_INTEGER, 8'h01};
    send_message(1'b1, 1'b1);
  endtask

  // A bad inner tag after one full integer: the rest is swallowed and the
  // status counts only the completed integer.
  task automatic test_malformed();
    write_limit(16'd512);
    msg = '{disd_pkg::TAG_SEQUENCE, 8'h05, disd_pkg::TAG_INTEGER, 8'h01, 8'h11, 8'h07,
            8'h00};
    send_message(1'b1, 1'b1);
  endtask

  // A long message without idling: two-byte lengths on the outer header and
  // on one 260-byte integer, whose byte significance runs past one byte.
  task automatic test_long_message();
    write_limit(16'hFFFF);
    calm = 1'b1;
    send_byte(disd_pkg::TAG_SEQUENCE, 1'b1, 1'b0);
    send_byte(disd_pkg::LEN_TWO_BYTE, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h08, 1'b0, 1'b0);
    send_byte(disd_pkg::TAG_INTEGER, 1'b0, 1'b0);
    send_byte(disd_pkg::LEN_TWO_BYTE, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h04, 1'b0, 1'b0);
    for (int i = 0; i < 260; i++) begin
      send_byte(8'($urandom), 1'b0, i == 259);
    end
    calm = 1'b0;
  endtask

  // Random messages in several phases, each with its own length limit.
  task automatic test_random_messages();
    int phase_end;
    for (int p = 0; p < 4; p++) begin
      write_limit(($urandom_range(3) == 0) ? 16'($urandom_range(128, 300))
                                           : 16'($urandom_range(1, 5)));
      phase_end = sent_items + 250;
      while (sent_items < phase_end) begin
        build_random_message();
        send_message($urandom_range(9) != 0, $urandom_range(9) != 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    int_limit = disd_pkg::MAX_INT_BYTES_RST;
    reset_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_well_formed();
    test_zero_limit();
    test_malformed();
    test_long_message();
    test_random_messages();
    settle();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
